>>> rtl/aak_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive altitude Kalman filter package
// Shared constants, register indexes, divider widths and saturation helpers.
// ----------------------------------------------------------------------------
package aak_pkg;

    localparam int DivNumW = 64;
    localparam int DivDenW = 34;
    localparam int DivCntW = $clog2(DivNumW);

    localparam logic [31:0] OneQ16      = 32'd65536;
    localparam logic [31:0] QuarterQ16  = 32'd16384;
    localparam logic [31:0] HalfQ16     = 32'd32768;
    localparam logic [15:0] DefaultAlpha = 16'd3277;

    localparam logic [2:0] RegAccelVar     = 3'd0;
    localparam logic [2:0] RegMeasVar      = 3'd1;
    localparam logic [2:0] RegGateThreshold = 3'd2;
    localparam logic [2:0] RegMaxInflate   = 3'd3;
    localparam logic [2:0] RegBiasAlpha    = 3'd4;

    localparam logic signed [35:0] SumMax = 36'sd2147483647;
    localparam logic signed [35:0] SumMin = -36'sd2147483648;

    function automatic logic signed [35:0] ext36(input logic signed [31:0] x);
        return 36'(x);
    endfunction

    function automatic logic signed [31:0] sat_sum(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > SumMax) begin
            r = 32'sh7FFFFFFF;
        end else if (x < SumMin) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (m > 64'd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = (~m[31:0]) + 32'd1;
            end
        end else begin
            if (m > 64'd2147483647) begin
                r = 32'sh7FFFFFFF;
            end else begin
                r = m[31:0];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/aak_div.sv
// ----------------------------------------------------------------------------
// Adaptive altitude Kalman filter divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aak_div
    import aak_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DivNumW-1:0] num,
    input  logic [DivDenW-1:0] den,
    output logic               done,
    output logic [DivNumW-1:0] quot
);

    logic [DivNumW-1:0] quo_reg;
    logic [DivDenW-1:0] rem_reg;
    logic [DivDenW-1:0] den_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DivDenW:0]   trial;
    logic [DivDenW:0]   diff;
    logic               ge;

    assign trial = {rem_reg, quo_reg[DivNumW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
                quo_reg <= {quo_reg[DivNumW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DivCntW'(DivNumW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> rtl/adaptive_altitude_kalman.sv
// ----------------------------------------------------------------------------
// Adaptive altitude Kalman filter
// Two-state altitude and velocity filter in Q16.16 with innovation-gated
// covariance inflation, built on one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// A load beat goes from ST_IDLE to ST_DONE, which registers the result and raises
// out_valid once the output is free. A filter beat's duration is set mostly by the
// 64-step radix-2 divider, used for each of the five gain divisions and the inflation ratio.
// A beat whose innovation variance is not positive ends early, without the gain update.
// Throughput: one beat at a time; in_stall is high until the result registers.
// Reset: asynchronous, clears the filter state and loads register defaults.
// ----------------------------------------------------------------------------
module adaptive_altitude_kalman
    import aak_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [31:0] altitude_in,
    input  logic [23:0]        dt_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] altitude_est,
    output logic signed [31:0] velocity_est,
    output logic [30:0]        altitude_variance,
    output logic               inflated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] PH_MUL = 2'd0;
    localparam logic [1:0] PH_DLD = 2'd1;
    localparam logic [1:0] PH_DIV = 2'd2;
    localparam logic [1:0] PH_WB  = 2'd3;

    localparam logic [4:0] OP_DT2   = 5'd0;
    localparam logic [4:0] OP_DT3   = 5'd1;
    localparam logic [4:0] OP_DT4   = 5'd2;
    localparam logic [4:0] OP_QA4   = 5'd3;
    localparam logic [4:0] OP_Q00   = 5'd4;
    localparam logic [4:0] OP_QA3   = 5'd5;
    localparam logic [4:0] OP_Q01   = 5'd6;
    localparam logic [4:0] OP_Q11   = 5'd7;
    localparam logic [4:0] OP_DTP   = 5'd8;
    localparam logic [4:0] OP_VDT   = 5'd9;
    localparam logic [4:0] OP_HH    = 5'd10;
    localparam logic [4:0] OP_SETUP = 5'd11;
    localparam logic [4:0] OP_BIAS  = 5'd12;
    localparam logic [4:0] OP_EDIV  = 5'd13;
    localparam logic [4:0] OP_LAM   = 5'd14;
    localparam logic [4:0] OP_L00   = 5'd15;
    localparam logic [4:0] OP_L01   = 5'd16;
    localparam logic [4:0] OP_L11   = 5'd17;
    localparam logic [4:0] OP_K0    = 5'd18;
    localparam logic [4:0] OP_K1    = 5'd19;
    localparam logic [4:0] OP_C00   = 5'd20;
    localparam logic [4:0] OP_C01   = 5'd21;
    localparam logic [4:0] OP_C11   = 5'd22;
    localparam logic [4:0] OP_DONE  = 5'd23;

    function automatic logic [1:0] first_ph(input logic [4:0] op);
        logic [1:0] r;
        if (op == OP_SETUP) begin
            r = PH_WB;
        end else if (op == OP_EDIV) begin
            r = PH_DLD;
        end else begin
            r = PH_MUL;
        end
        return r;
    endfunction

    logic [31:0] accel_var_reg;
    logic [31:0] meas_var_reg;
    logic [31:0] gate_reg;
    logic [31:0] max_inflate_reg;
    logic [15:0] bias_alpha_reg;

    logic [1:0] state_reg;
    logic [1:0] ph_reg;
    logic [4:0] op_reg;

    logic signed [31:0] z_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] alt_reg, vel_reg, phh_reg, phv_reg, pvv_reg, bias_reg;
    logic               started_reg;

    logic signed [31:0] dt2_reg, dt3_reg, dt4_reg, ta_reg, q00_reg, q01_reg, q11_reg;
    logic signed [31:0] dtp_reg, t_reg, y_reg, d_reg;
    logic signed [31:0] p00_reg, p01_reg, p11_reg;
    logic [31:0]        e_reg, lam_reg;
    logic signed [33:0] s_reg;
    logic               infl_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_alt_reg, out_vel_reg;
    logic [30:0]        out_var_reg;
    logic               out_infl_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        mag_a, mag_b;
    logic [64:0]        rnd_sum;
    logic [48:0]        rnd;
    logic signed [31:0] mq, dq;
    logic [15:0]        alpha_eff;
    logic [31:0]        lim;
    logic signed [33:0] s_calc, s_infl;
    logic signed [31:0] y_calc, d_calc, bias_new;
    logic [31:0]        bias_new_mag, bias_mag;
    logic [4:0]         next_op;
    logic               is_div_op;

    logic               div_start, div_done;
    logic [DivNumW-1:0] div_num, div_quot;
    logic [DivDenW-1:0] div_den;

    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            RegAccelVar:      prdata = accel_var_reg;
            RegMeasVar:       prdata = meas_var_reg;
            RegGateThreshold: prdata = gate_reg;
            RegMaxInflate:    prdata = max_inflate_reg;
            RegBiasAlpha:     prdata = {16'd0, bias_alpha_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign alpha_eff = (bias_alpha_reg != 16'd0) ? bias_alpha_reg : DefaultAlpha;
    assign lim       = (max_inflate_reg < OneQ16) ? OneQ16 : max_inflate_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_DT2:  begin mul_a = $signed({9'd0, dt_reg});  mul_b = $signed({9'd0, dt_reg}); end
            OP_DT3:  begin mul_a = 33'(dt2_reg);             mul_b = $signed({9'd0, dt_reg}); end
            OP_DT4:  begin mul_a = 33'(dt2_reg);             mul_b = 33'(dt2_reg); end
            OP_QA4:  begin mul_a = $signed({1'b0, accel_var_reg}); mul_b = 33'(dt4_reg); end
            OP_Q00:  begin mul_a = 33'(ta_reg);              mul_b = $signed({1'b0, QuarterQ16}); end
            OP_QA3:  begin mul_a = $signed({1'b0, accel_var_reg}); mul_b = 33'(dt3_reg); end
            OP_Q01:  begin mul_a = 33'(ta_reg);              mul_b = $signed({1'b0, HalfQ16}); end
            OP_Q11:  begin mul_a = $signed({1'b0, accel_var_reg}); mul_b = 33'(dt2_reg); end
            OP_DTP:  begin mul_a = $signed({9'd0, dt_reg});  mul_b = 33'(pvv_reg); end
            OP_VDT:  begin mul_a = 33'(vel_reg);             mul_b = $signed({9'd0, dt_reg}); end
            OP_HH:   begin mul_a = $signed({9'd0, dt_reg});  mul_b = 33'(t_reg); end
            OP_BIAS: begin mul_a = 33'(d_reg);               mul_b = $signed({17'd0, alpha_eff}); end
            OP_LAM:  begin mul_a = $signed({1'b0, e_reg});   mul_b = $signed({1'b0, e_reg}); end
            OP_L00:  begin mul_a = 33'(p00_reg);             mul_b = $signed({1'b0, lam_reg}); end
            OP_L01:  begin mul_a = 33'(p01_reg);             mul_b = $signed({1'b0, lam_reg}); end
            OP_L11:  begin mul_a = 33'(p11_reg);             mul_b = $signed({1'b0, lam_reg}); end
            OP_K0:   begin mul_a = 33'(y_reg);               mul_b = 33'(p00_reg); end
            OP_K1:   begin mul_a = 33'(y_reg);               mul_b = 33'(p01_reg); end
            OP_C00:  begin mul_a = 33'(p00_reg);             mul_b = 33'(p00_reg); end
            OP_C01:  begin mul_a = 33'(p00_reg);             mul_b = 33'(p01_reg); end
            OP_C11:  begin mul_a = 33'(p01_reg);             mul_b = 33'(p01_reg); end
            default: begin mul_a = '0;                       mul_b = '0; end
        endcase
    end

    assign mag_a   = mul_a[32] ? 32'(-mul_a) : mul_a[31:0];
    assign mag_b   = mul_b[32] ? 32'(-mul_b) : mul_b[31:0];
    assign rnd_sum = {1'b0, prod_reg} + 65'h8000;
    assign rnd     = rnd_sum[64:16];
    assign mq      = sat_mag(64'(rnd), neg_reg);
    assign dq      = sat_mag(div_quot, neg_reg);

    assign s_calc = $signed({{2{phh_reg[31]}}, phh_reg}) + $signed({2'b00, meas_var_reg});
    assign s_infl = $signed({{2{p00_reg[31]}}, p00_reg}) + $signed({2'b00, meas_var_reg});
    assign y_calc = sat_sum(ext36(z_reg) - ext36(alt_reg));
    assign d_calc = sat_sum(ext36(y_calc) - ext36(bias_reg));
    assign bias_new     = sat_sum(ext36(bias_reg) + ext36(mq));
    assign bias_new_mag = bias_new[31] ? (~bias_new + 32'd1) : bias_new;
    assign bias_mag     = bias_reg[31] ? (~bias_reg + 32'd1) : bias_reg;

    assign is_div_op = op_reg inside {OP_K0, OP_K1, OP_C00, OP_C01, OP_C11};

    always_comb
    begin
        unique case (op_reg)
            OP_DT2:   next_op = OP_DT3;
            OP_DT3:   next_op = OP_DT4;
            OP_DT4:   next_op = OP_QA4;
            OP_QA4:   next_op = OP_Q00;
            OP_Q00:   next_op = OP_QA3;
            OP_QA3:   next_op = OP_Q01;
            OP_Q01:   next_op = OP_Q11;
            OP_Q11:   next_op = OP_DTP;
            OP_DTP:   next_op = OP_VDT;
            OP_VDT:   next_op = OP_HH;
            OP_HH:    next_op = OP_SETUP;
            OP_SETUP: next_op = (s_calc <= 34'sd0) ? OP_DONE
                              : ((gate_reg != 32'd0) ? OP_BIAS : OP_K0);
            OP_BIAS:  next_op = (bias_new_mag > gate_reg) ? OP_EDIV : OP_K0;
            OP_EDIV:  next_op = OP_LAM;
            OP_LAM:   next_op = OP_L00;
            OP_L00:   next_op = OP_L01;
            OP_L01:   next_op = OP_L11;
            OP_L11:   next_op = (s_infl <= 34'sd0) ? OP_DONE : OP_K0;
            OP_K0:    next_op = OP_K1;
            OP_K1:    next_op = OP_C00;
            OP_C00:   next_op = OP_C01;
            OP_C01:   next_op = OP_C11;
            default:  next_op = OP_DONE;
        endcase
    end

    assign div_start = (state_reg == ST_RUN) && (ph_reg == PH_DLD);
    assign div_num   = (op_reg == OP_EDIV) ? {16'd0, bias_mag, 16'd0}
                                           : prod_reg + 64'(s_reg[33:1]);
    assign div_den   = (op_reg == OP_EDIV) ? {2'b00, gate_reg} : s_reg[33:0];

    aak_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_var_reg   <= OneQ16;
            meas_var_reg    <= OneQ16;
            gate_reg        <= 32'd0;
            max_inflate_reg <= OneQ16;
            bias_alpha_reg  <= DefaultAlpha;
            state_reg       <= ST_IDLE;
            ph_reg          <= PH_MUL;
            op_reg          <= OP_DONE;
            alt_reg         <= '0;
            vel_reg         <= '0;
            phh_reg         <= '0;
            phv_reg         <= '0;
            pvv_reg         <= '0;
            bias_reg        <= '0;
            started_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            z_reg <= '0; dt_reg <= '0;
            dt2_reg <= '0; dt3_reg <= '0; dt4_reg <= '0; ta_reg <= '0;
            q00_reg <= '0; q01_reg <= '0; q11_reg <= '0; dtp_reg <= '0;
            t_reg <= '0; y_reg <= '0; d_reg <= '0;
            p00_reg <= '0; p01_reg <= '0; p11_reg <= '0;
            e_reg <= '0; lam_reg <= '0; s_reg <= '0; infl_reg <= 1'b0;
            prod_reg <= '0; neg_reg <= 1'b0;
            out_alt_reg <= '0; out_vel_reg <= '0; out_var_reg <= '0; out_infl_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    RegAccelVar:      accel_var_reg   <= pwdata;
                    RegMeasVar:       meas_var_reg    <= pwdata;
                    RegGateThreshold: gate_reg        <= pwdata;
                    RegMaxInflate:    max_inflate_reg <= pwdata;
                    RegBiasAlpha:     bias_alpha_reg  <= pwdata[15:0];
                    default:          ;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        z_reg    <= altitude_in;
                        dt_reg   <= dt_in;
                        infl_reg <= 1'b0;
                        if (command || !started_reg)
                        begin
                            alt_reg     <= altitude_in;
                            vel_reg     <= '0;
                            phh_reg     <= meas_var_reg[31] ? 32'sh7FFFFFFF : meas_var_reg;
                            phv_reg     <= '0;
                            pvv_reg     <= OneQ16;
                            bias_reg    <= '0;
                            started_reg <= 1'b1;
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                            if (dt_in != 24'd0)
                            begin
                                op_reg <= OP_DT2;
                                ph_reg <= PH_MUL;
                            end
                            else
                            begin
                                op_reg <= OP_SETUP;
                                ph_reg <= PH_WB;
                            end
                        end
                    end
                end

                ST_RUN:
                begin
                    unique case (ph_reg)
                        PH_MUL:
                        begin
                            prod_reg <= 64'(mag_a) * 64'(mag_b);
                            neg_reg  <= mul_a[32] ^ mul_b[32];
                            ph_reg   <= is_div_op ? PH_DLD : PH_WB;
                        end
                        PH_DLD:
                        begin
                            ph_reg <= PH_DIV;
                        end
                        PH_DIV:
                        begin
                            if (div_done)
                            begin
                                ph_reg <= PH_WB;
                            end
                        end
                        PH_WB:
                        begin
                            unique case (op_reg)
                                OP_DT2: dt2_reg <= mq;
                                OP_DT3: dt3_reg <= mq;
                                OP_DT4: dt4_reg <= mq;
                                OP_QA4: ta_reg  <= mq;
                                OP_Q00: q00_reg <= mq;
                                OP_QA3: ta_reg  <= mq;
                                OP_Q01: q01_reg <= mq;
                                OP_Q11: q11_reg <= mq;
                                OP_DTP:
                                begin
                                    dtp_reg <= mq;
                                    t_reg   <= sat_sum(ext36(phv_reg) + ext36(phv_reg) + ext36(mq));
                                end
                                OP_VDT: alt_reg <= sat_sum(ext36(alt_reg) + ext36(mq));
                                OP_HH:
                                begin
                                    phh_reg <= sat_sum(ext36(phh_reg) + ext36(mq) + ext36(q00_reg));
                                    phv_reg <= sat_sum(ext36(phv_reg) + ext36(dtp_reg)
                                                       + ext36(q01_reg));
                                    pvv_reg <= sat_sum(ext36(pvv_reg) + ext36(q11_reg));
                                end
                                OP_SETUP:
                                begin
                                    s_reg   <= s_calc;
                                    y_reg   <= y_calc;
                                    d_reg   <= d_calc;
                                    p00_reg <= phh_reg;
                                    p01_reg <= phv_reg;
                                    p11_reg <= pvv_reg;
                                end
                                OP_BIAS: bias_reg <= bias_new;
                                OP_EDIV: e_reg <= (|div_quot[63:32]) ? 32'hFFFFFFFF
                                                                     : div_quot[31:0];
                                OP_LAM:  lam_reg <= (rnd > 49'(lim)) ? lim : rnd[31:0];
                                OP_L00:  p00_reg <= mq;
                                OP_L01:  p01_reg <= mq;
                                OP_L11:
                                begin
                                    p11_reg  <= mq;
                                    s_reg    <= s_infl;
                                    infl_reg <= 1'b1;
                                    if (s_infl <= 34'sd0)
                                    begin
                                        phh_reg <= p00_reg;
                                        phv_reg <= p01_reg;
                                        pvv_reg <= mq;
                                    end
                                end
                                OP_K0:  alt_reg <= sat_sum(ext36(alt_reg) + ext36(dq));
                                OP_K1:  vel_reg <= sat_sum(ext36(vel_reg) + ext36(dq));
                                OP_C00: phh_reg <= sat_sum(ext36(p00_reg) - ext36(dq));
                                OP_C01: phv_reg <= sat_sum(ext36(p01_reg) - ext36(dq));
                                OP_C11: pvv_reg <= sat_sum(ext36(p11_reg) - ext36(dq));
                                default: ;
                            endcase
                            op_reg <= next_op;
                            ph_reg <= first_ph(next_op);
                            if (next_op == OP_DONE)
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        default: ph_reg <= PH_MUL;
                    endcase
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_alt_reg   <= alt_reg;
                        out_vel_reg   <= vel_reg;
                        out_var_reg   <= phh_reg[31] ? 31'd0 : phh_reg[30:0];
                        out_infl_reg  <= infl_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign altitude_est      = out_alt_reg;
    assign velocity_est      = out_vel_reg;
    assign altitude_variance = out_var_reg;
    assign inflated          = out_infl_reg;

endmodule

>>> rtl/aak_checker.sv
// ----------------------------------------------------------------------------
// Adaptive altitude Kalman filter checker
// Port-level properties of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module aak_checker
    import aak_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               command,
    input logic signed [31:0] altitude_in,
    input logic [23:0]        dt_in,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] altitude_est,
    input logic signed [31:0] velocity_est,
    input logic [30:0]        altitude_variance,
    input logic               inflated,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [4:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // The block works on a single beat, so it stalls right after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // A result only appears after the block has been busy on a beat.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a beat in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(altitude_est) && $stable(velocity_est)
            && $stable(altitude_variance) && $stable(inflated)))
        else $error("result changed while stalled");

endmodule

bind adaptive_altitude_kalman aak_checker u_aak_checker (.*);
